[rtl/qvr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared defaults for the quaternion vector rotation core.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // Fraction bits of the quaternion parts (1.0 = 2^QUAT_FRAC_BITS)
  localparam int unsigned QVR_QUAT_FRAC_BITS = 16;
  // Width of the vector components in and out
  localparam int unsigned QVR_VEC_BITS       = 24;

endpackage

[rtl/qvr_lhs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_lhs
// Left product p = q * (0,v): one stage of twelve products, then one stage
// that sums, rounds half up and registers the four parts of p. The
// quaternion travels alongside for the right product.
// ----------------------------------------------------------------------------
module qvr_lhs import qvr_pkg::*; #(
  parameter int unsigned QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS,
  parameter int unsigned VEC_BITS       = QVR_VEC_BITS,
  localparam int unsigned QB = QUAT_FRAC_BITS + 2,
  localparam int unsigned PW = VEC_BITS + 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [QB-1:0]       qw,
  input  logic signed [QB-1:0]       qx,
  input  logic signed [QB-1:0]       qy,
  input  logic signed [QB-1:0]       qz,
  input  logic signed [VEC_BITS-1:0] vx,
  input  logic signed [VEC_BITS-1:0] vy,
  input  logic signed [VEC_BITS-1:0] vz,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [PW-1:0]       p0,
  output logic signed [PW-1:0]       p1,
  output logic signed [PW-1:0]       p2,
  output logic signed [PW-1:0]       p3,
  output logic signed [QB-1:0]       qw_o,
  output logic signed [QB-1:0]       qx_o,
  output logic signed [QB-1:0]       qy_o,
  output logic signed [QB-1:0]       qz_o
);

  localparam int unsigned MW = QB + VEC_BITS;
  localparam int unsigned SW = QB + VEC_BITS + 1;
  localparam logic signed [SW-1:0] HALF =
    {{(SW-QUAT_FRAC_BITS){1'b0}}, 1'b1, {(QUAT_FRAC_BITS-1){1'b0}}};

  logic s1_vld_r, s2_vld_r, s1_rdy, s2_rdy;

  logic signed [MW-1:0] m_xvx_r, m_yvy_r, m_zvz_r;
  logic signed [MW-1:0] m_wvx_r, m_yvz_r, m_zvy_r;
  logic signed [MW-1:0] m_wvy_r, m_xvz_r, m_zvx_r;
  logic signed [MW-1:0] m_wvz_r, m_xvy_r, m_yvx_r;
  logic signed [QB-1:0] s1_qw_r, s1_qx_r, s1_qy_r, s1_qz_r;
  logic signed [QB-1:0] s2_qw_r, s2_qx_r, s2_qy_r, s2_qz_r;

  logic signed [SW-1:0] sum0, sum1, sum2, sum3;
  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;

  // Stall chain: a stage takes an item when empty or when it drains
  assign s2_rdy   = !s2_vld_r || out_ready;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_valid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
    end
  end

  // Stage 1: register the twelve products
  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      m_xvx_r <= qx * vx;
      m_yvy_r <= qy * vy;
      m_zvz_r <= qz * vz;
      m_wvx_r <= qw * vx;
      m_yvz_r <= qy * vz;
      m_zvy_r <= qz * vy;
      m_wvy_r <= qw * vy;
      m_xvz_r <= qx * vz;
      m_zvx_r <= qz * vx;
      m_wvz_r <= qw * vz;
      m_xvy_r <= qx * vy;
      m_yvx_r <= qy * vx;
      s1_qw_r <= qw;
      s1_qx_r <= qx;
      s1_qy_r <= qy;
      s1_qz_r <= qz;
    end
  end

  // Stage 2: sum, round half up, drop the fraction bits
  always_comb begin
    sum0 = HALF - SW'(m_xvx_r) - SW'(m_yvy_r) - SW'(m_zvz_r);
    sum1 = HALF + SW'(m_wvx_r) + SW'(m_yvz_r) - SW'(m_zvy_r);
    sum2 = HALF + SW'(m_wvy_r) - SW'(m_xvz_r) + SW'(m_zvx_r);
    sum3 = HALF + SW'(m_wvz_r) + SW'(m_xvy_r) - SW'(m_yvx_r);
    p0_nxt = sum0[SW-1:QUAT_FRAC_BITS];
    p1_nxt = sum1[SW-1:QUAT_FRAC_BITS];
    p2_nxt = sum2[SW-1:QUAT_FRAC_BITS];
    p3_nxt = sum3[SW-1:QUAT_FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      p3_r    <= p3_nxt;
      s2_qw_r <= s1_qw_r;
      s2_qx_r <= s1_qx_r;
      s2_qy_r <= s1_qy_r;
      s2_qz_r <= s1_qz_r;
    end
  end

  assign out_valid = s2_vld_r;
  assign p0   = p0_r;
  assign p1   = p1_r;
  assign p2   = p2_r;
  assign p3   = p3_r;
  assign qw_o = s2_qw_r;
  assign qx_o = s2_qx_r;
  assign qy_o = s2_qy_r;
  assign qz_o = s2_qz_r;

endmodule

[rtl/qvr_rhs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_rhs
// Right product r = p * conj(q), vector part only: one stage of twelve
// products, then one stage that sums, rounds half up and registers r.
// ----------------------------------------------------------------------------
module qvr_rhs import qvr_pkg::*; #(
  parameter int unsigned QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS,
  parameter int unsigned VEC_BITS       = QVR_VEC_BITS,
  localparam int unsigned QB = QUAT_FRAC_BITS + 2,
  localparam int unsigned PW = VEC_BITS + 3,
  localparam int unsigned RW = VEC_BITS + 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [PW-1:0] p0,
  input  logic signed [PW-1:0] p1,
  input  logic signed [PW-1:0] p2,
  input  logic signed [PW-1:0] p3,
  input  logic signed [QB-1:0] qw,
  input  logic signed [QB-1:0] qx,
  input  logic signed [QB-1:0] qy,
  input  logic signed [QB-1:0] qz,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [RW-1:0] r1,
  output logic signed [RW-1:0] r2,
  output logic signed [RW-1:0] r3
);

  localparam int unsigned MW = PW + QB;
  localparam int unsigned SW = PW + QB + 1;
  localparam logic signed [SW-1:0] HALF =
    {{(SW-QUAT_FRAC_BITS){1'b0}}, 1'b1, {(QUAT_FRAC_BITS-1){1'b0}}};

  logic s3_vld_r, s4_vld_r, s3_rdy, s4_rdy;

  logic signed [MW-1:0] m_p0x_r, m_p1w_r, m_p2z_r, m_p3y_r;
  logic signed [MW-1:0] m_p0y_r, m_p1z_r, m_p2w_r, m_p3x_r;
  logic signed [MW-1:0] m_p0z_r, m_p1y_r, m_p2x_r, m_p3w_r;

  logic signed [SW-1:0] sum1, sum2, sum3;
  logic signed [RW-1:0] r1_nxt, r2_nxt, r3_nxt;
  logic signed [RW-1:0] r1_r, r2_r, r3_r;

  // Stall chain
  assign s4_rdy   = !s4_vld_r || out_ready;
  assign s3_rdy   = !s3_vld_r || s4_rdy;
  assign in_ready = s3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s3_rdy) s3_vld_r <= in_valid;
      if (s4_rdy) s4_vld_r <= s3_vld_r;
    end
  end

  // Stage 3: register the twelve products
  always_ff @(posedge clk) begin
    if (s3_rdy && in_valid) begin
      m_p0x_r <= p0 * qx;
      m_p1w_r <= p1 * qw;
      m_p2z_r <= p2 * qz;
      m_p3y_r <= p3 * qy;
      m_p0y_r <= p0 * qy;
      m_p1z_r <= p1 * qz;
      m_p2w_r <= p2 * qw;
      m_p3x_r <= p3 * qx;
      m_p0z_r <= p0 * qz;
      m_p1y_r <= p1 * qy;
      m_p2x_r <= p2 * qx;
      m_p3w_r <= p3 * qw;
    end
  end

  // Stage 4: sum with conjugate signs, round half up, drop fraction bits
  always_comb begin
    sum1 = HALF - SW'(m_p0x_r) + SW'(m_p1w_r) - SW'(m_p2z_r) + SW'(m_p3y_r);
    sum2 = HALF - SW'(m_p0y_r) + SW'(m_p1z_r) + SW'(m_p2w_r) - SW'(m_p3x_r);
    sum3 = HALF - SW'(m_p0z_r) - SW'(m_p1y_r) + SW'(m_p2x_r) + SW'(m_p3w_r);
    r1_nxt = sum1[SW-1:QUAT_FRAC_BITS];
    r2_nxt = sum2[SW-1:QUAT_FRAC_BITS];
    r3_nxt = sum3[SW-1:QUAT_FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_vld_r) begin
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
      r3_r <= r3_nxt;
    end
  end

  assign out_valid = s4_vld_r;
  assign r1 = r1_r;
  assign r2 = r2_r;
  assign r3 = r3_r;

endmodule

[rtl/qvr_sat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_sat
// Output stage: clamp each component to the vector width, flag any clamp,
// and hold the result item in the output register.
// ----------------------------------------------------------------------------
module qvr_sat import qvr_pkg::*; #(
  parameter int unsigned VEC_BITS = QVR_VEC_BITS,
  localparam int unsigned RW = VEC_BITS + 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [RW-1:0]       r1,
  input  logic signed [RW-1:0]       r2,
  input  logic signed [RW-1:0]       r3,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VEC_BITS-1:0] rot_x,
  output logic signed [VEC_BITS-1:0] rot_y,
  output logic signed [VEC_BITS-1:0] rot_z,
  output logic                       clipped
);

  localparam logic signed [RW-1:0] R_HI =
    {{(RW-VEC_BITS+1){1'b0}}, {(VEC_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] R_LO =
    {{(RW-VEC_BITS+1){1'b1}}, {(VEC_BITS-1){1'b0}}};
  localparam logic signed [VEC_BITS-1:0] V_HI = {1'b0, {(VEC_BITS-1){1'b1}}};
  localparam logic signed [VEC_BITS-1:0] V_LO = {1'b1, {(VEC_BITS-1){1'b0}}};

  logic s5_vld_r, s5_rdy;
  logic hi1, lo1, hi2, lo2, hi3, lo3;
  logic signed [VEC_BITS-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [VEC_BITS-1:0] x_r, y_r, z_r;
  logic clip_nxt, clip_r;

  assign s5_rdy   = !s5_vld_r || out_ready;
  assign in_ready = s5_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (s5_rdy) begin
      s5_vld_r <= in_valid;
    end
  end

  // Clamp to the signed vector range
  always_comb begin
    hi1 = r1 > R_HI;
    lo1 = r1 < R_LO;
    hi2 = r2 > R_HI;
    lo2 = r2 < R_LO;
    hi3 = r3 > R_HI;
    lo3 = r3 < R_LO;
    x_nxt = hi1 ? V_HI : (lo1 ? V_LO : r1[VEC_BITS-1:0]);
    y_nxt = hi2 ? V_HI : (lo2 ? V_LO : r2[VEC_BITS-1:0]);
    z_nxt = hi3 ? V_HI : (lo3 ? V_LO : r3[VEC_BITS-1:0]);
    clip_nxt = hi1 | lo1 | hi2 | lo2 | hi3 | lo3;
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && in_valid) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid = s5_vld_r;
  assign rot_x     = x_r;
  assign rot_y     = y_r;
  assign rot_z     = z_r;
  assign clipped   = clip_r;

endmodule

[rtl/quaternion_vector_rotation_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_core
// Rotates a vector by a fixed-point quaternion, r = q * (0,v) * conj(q),
// with half-up rounding after each product and saturation at the output.
//
//   Channel  Direction  Handshake                Payload
//   in_      input      in_valid / in_ready      in_quat_w..z, in_vec_x..z
//   out_     output     out_valid / out_ready    out_rot_x..z, out_clipped
//
// An item passes five register stages, one after the other; one item is
// accepted per cycle unless out_ready stalls the full pipeline. The stages
// are: left products, left sum and round, right products, right sum and
// round, clamp and output register.
// Each stage holds its item while the next is full and fills a bubble as
// soon as one opens, so a stall drops nothing. Synchronous active-low reset
// empties the pipeline.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_core import qvr_pkg::*; #(
  parameter int unsigned QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS,
  parameter int unsigned VEC_BITS       = QVR_VEC_BITS,
  localparam int unsigned QB = QUAT_FRAC_BITS + 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [QB-1:0]       in_quat_w,
  input  logic signed [QB-1:0]       in_quat_x,
  input  logic signed [QB-1:0]       in_quat_y,
  input  logic signed [QB-1:0]       in_quat_z,
  input  logic signed [VEC_BITS-1:0] in_vec_x,
  input  logic signed [VEC_BITS-1:0] in_vec_y,
  input  logic signed [VEC_BITS-1:0] in_vec_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VEC_BITS-1:0] out_rot_x,
  output logic signed [VEC_BITS-1:0] out_rot_y,
  output logic signed [VEC_BITS-1:0] out_rot_z,
  output logic                       out_clipped
);

  localparam int unsigned PW = VEC_BITS + 3;
  localparam int unsigned RW = VEC_BITS + 6;

  logic                 l_valid, l_ready;
  logic signed [PW-1:0] p0, p1, p2, p3;
  logic signed [QB-1:0] qw_d, qx_d, qy_d, qz_d;
  logic                 r_valid, r_ready;
  logic signed [RW-1:0] r1, r2, r3;

  // Left product q * (0,v)
  qvr_lhs #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .VEC_BITS       (VEC_BITS)
  ) u_lhs (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .qw        (in_quat_w),
    .qx        (in_quat_x),
    .qy        (in_quat_y),
    .qz        (in_quat_z),
    .vx        (in_vec_x),
    .vy        (in_vec_y),
    .vz        (in_vec_z),
    .out_valid (l_valid),
    .out_ready (l_ready),
    .p0        (p0),
    .p1        (p1),
    .p2        (p2),
    .p3        (p3),
    .qw_o      (qw_d),
    .qx_o      (qx_d),
    .qy_o      (qy_d),
    .qz_o      (qz_d)
  );

  // Right product p * conj(q)
  qvr_rhs #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
    .VEC_BITS       (VEC_BITS)
  ) u_rhs (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (l_valid),
    .in_ready  (l_ready),
    .p0        (p0),
    .p1        (p1),
    .p2        (p2),
    .p3        (p3),
    .qw        (qw_d),
    .qx        (qx_d),
    .qy        (qy_d),
    .qz        (qz_d),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .r1        (r1),
    .r2        (r2),
    .r3        (r3)
  );

  // Clamp and output register
  qvr_sat #(
    .VEC_BITS (VEC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .r1        (r1),
    .r2        (r2),
    .r3        (r3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rot_x     (out_rot_x),
    .rot_y     (out_rot_y),
    .rot_z     (out_rot_z),
    .clipped   (out_clipped)
  );

endmodule

[rtl/qvr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_checker
// Port-level checks for the rotation core, bound to the top level.
// ----------------------------------------------------------------------------
module qvr_checker import qvr_pkg::*; #(
  parameter int unsigned VEC_BITS = QVR_VEC_BITS
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [VEC_BITS-1:0] out_rot_x,
  input logic signed [VEC_BITS-1:0] out_rot_y,
  input logic signed [VEC_BITS-1:0] out_rot_z,
  input logic                       out_clipped
);

  localparam logic signed [VEC_BITS-1:0] V_HI = {1'b0, {(VEC_BITS-1){1'b1}}};
  localparam logic signed [VEC_BITS-1:0] V_LO = {1'b1, {(VEC_BITS-1){1'b0}}};

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rot_x) &&
    $stable(out_rot_y) && $stable(out_rot_z) && $stable(out_clipped))
    else $error("result item changed while stalled");

  // The input side only backs up when every stage, output included, is full
  a_no_early_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with an empty output register");

  // A clip flag means some component sits at a range limit
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
    out_rot_x == V_HI || out_rot_x == V_LO || out_rot_y == V_HI ||
    out_rot_y == V_LO || out_rot_z == V_HI || out_rot_z == V_LO)
    else $error("clipped set with no component at a limit");

endmodule

bind quaternion_vector_rotation_core qvr_checker #(
  .VEC_BITS (VEC_BITS)
) u_qvr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_rot_x   (out_rot_x),
  .out_rot_y   (out_rot_y),
  .out_rot_z   (out_rot_z),
  .out_clipped (out_clipped)
);
